[hdl/bssc_pkg.sv]
package bssc_pkg;

  // field widths fixed by the channel format
  localparam int unsigned PwmW  = 16;
  localparam int unsigned ModeW = 2;
  localparam int unsigned StepW = 3;
  localparam int unsigned PhaseW = 2;

  // internal duty storage width, 4..32
  localparam int unsigned DUTY_WIDTH = 16;

  localparam logic [ModeW-1:0] MODE_ALIGN = 2'd1;
  localparam logic [ModeW-1:0] MODE_RUN   = 2'd2;

  localparam logic [PhaseW-1:0] PH_A = 2'd0;
  localparam logic [PhaseW-1:0] PH_B = 2'd1;
  localparam logic [PhaseW-1:0] PH_C = 2'd2;

  localparam logic [StepW-1:0] STEP_LAST = 3'd5;

  // six-step table: high-side phase and low-side phase per step
  localparam logic [PhaseW-1:0] HIGH_OF [6] = '{PH_A, PH_A, PH_B, PH_B, PH_C, PH_C};
  localparam logic [PhaseW-1:0] LOW_OF  [6] = '{PH_B, PH_C, PH_C, PH_A, PH_A, PH_B};

  typedef logic [DUTY_WIDTH-1:0] duty_t;

  typedef struct packed {
    logic             seen;
    logic [StepW-1:0] pred;  // step that precedes the crossing
    logic [StepW-1:0] code;  // crossing code, 0..5
  } xing_t;

  typedef struct packed {
    duty_t      duty_a;
    duty_t      duty_b;
    duty_t      duty_c;
    logic [2:0] low_on;  // bit0 A, bit1 B, bit2 C
  } drive_t;

endpackage

[hdl/bssc_if.sv]
interface bssc_in_if import bssc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cross_a;
  logic             cross_b;
  logic             cross_c;
  logic [ModeW-1:0] motor_mode;
  logic [PwmW-1:0]  pwm_duty;

  modport source (output valid, cross_a, cross_b, cross_c, motor_mode, pwm_duty,
                  input ready);
  modport sink (input valid, cross_a, cross_b, cross_c, motor_mode, pwm_duty,
                output ready);
endinterface

interface bssc_out_if import bssc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PwmW-1:0]  duty_a;
  logic [PwmW-1:0]  duty_b;
  logic [PwmW-1:0]  duty_c;
  logic             low_a_on;
  logic             low_b_on;
  logic             low_c_on;
  logic             crossing_seen;
  logic             crossing_valid;
  logic             commutated;
  logic [StepW-1:0] step_now;

  modport source (output valid, duty_a, duty_b, duty_c, low_a_on, low_b_on, low_c_on,
                  crossing_seen, crossing_valid, commutated, step_now,
                  input ready);
  modport sink (input valid, duty_a, duty_b, duty_c, low_a_on, low_b_on, low_c_on,
                crossing_seen, crossing_valid, commutated, step_now,
                output ready);
endinterface

[hdl/bssc_xdetect.sv]
module bssc_xdetect import bssc_pkg::*; (
  input  logic [2:0] bits_i,
  input  logic [2:0] prev_i,
  output xing_t      xing_o
);

  logic [2:0]        changed;
  logic [PhaseW-1:0] phase;
  logic              rising;
  logic [StepW-1:0]  pred;

  assign changed = bits_i ^ prev_i;

  // first changed phase wins, A before B before C
  always_comb begin
    phase = PH_A;
    if (changed[0]) begin
      phase = PH_A;
    end else if (changed[1]) begin
      phase = PH_B;
    end else if (changed[2]) begin
      phase = PH_C;
    end
  end

  assign rising = bits_i[phase];
  assign pred   = {phase, 1'b0} + StepW'(!rising);

  assign xing_o.seen = |changed;
  assign xing_o.pred = pred;
  assign xing_o.code = (pred == STEP_LAST) ? '0 : pred + StepW'(1);

endmodule

[hdl/bssc_drive_table.sv]
module bssc_drive_table import bssc_pkg::*; (
  input  logic [StepW-1:0] step_i,
  input  duty_t            duty_i,
  output drive_t           drive_o
);

  logic [PhaseW-1:0] hi_ph;
  logic [PhaseW-1:0] lo_ph;

  always_comb begin
    hi_ph = PH_A;
    lo_ph = PH_B;
    case (step_i)
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5: begin
        hi_ph = HIGH_OF[step_i];
        lo_ph = LOW_OF[step_i];
      end
      default: begin
        hi_ph = PH_A;
        lo_ph = PH_B;
      end
    endcase
  end

  assign drive_o.duty_a = (hi_ph == PH_A) ? duty_i : '0;
  assign drive_o.duty_b = (hi_ph == PH_B) ? duty_i : '0;
  assign drive_o.duty_c = (hi_ph == PH_C) ? duty_i : '0;
  assign drive_o.low_on = {lo_ph == PH_C, lo_ph == PH_B, lo_ph == PH_A};

endmodule

[hdl/bemf_six_step_commutator_unit.sv]
// Six-step sensorless commutator fed by back-EMF zero-cross samples.
// in_i carries one sample per beat: the three comparator levels, the motor
// mode (align or run, anything else idle) and the PWM duty to apply if that
// sample commutates. out_o returns one beat per sample: the three high-side
// duties and low-side switches now driven, edge/valid/commutated flags and
// the commutation step after that sample.
// Each sample is held in the input register, then the edge decode, step
// update and table lookup settle into the result register. Throughput is one
// sample per clock while result beats are taken; the state update
// is a single registered pass, so back-to-back samples never wait on it.
// When the receiver stalls, the result register holds and the input register
// fills; ready drops only once both are occupied, and resumes the cycle the
// result beat is taken.
// Reset clears both stages, the stored comparator levels, the step (0) and
// all drives (all duties 0, all low-side switches off).
module bemf_six_step_commutator_unit import bssc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bssc_in_if.sink    in_i,
  bssc_out_if.source out_o
);

  typedef struct packed {
    drive_t           drive;
    logic             seen;
    logic             valid;
    logic             comm;
    logic [StepW-1:0] step;
  } result_t;

  // input register
  logic             s1_valid_q, s1_valid_d;
  logic [2:0]       s1_bits_q;
  logic [ModeW-1:0] s1_mode_q;
  duty_t            s1_duty_q;

  // state
  logic [2:0]       prev_q, prev_d;
  logic [StepW-1:0] step_q, step_d;
  drive_t           drive_q, drive_d;

  // result register
  logic             res_valid_q, res_valid_d;
  result_t          res_q, res_d;

  logic             in_fire, s1_fire, s2_ready;
  xing_t            xing;
  drive_t           table_drive;
  logic [StepW-1:0] step_aln;
  logic             xvalid, comm;

  assign s2_ready   = !res_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s2_ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign s1_fire    = s1_valid_q && s2_ready;

  bssc_xdetect u_xdetect (
    .bits_i (s1_bits_q),
    .prev_i (prev_q),
    .xing_o (xing)
  );

  bssc_drive_table u_table (
    .step_i  (xing.code),
    .duty_i  (s1_duty_q),
    .drive_o (table_drive)
  );

  always_comb begin
    step_aln = step_q;
    if (xing.seen && s1_mode_q == MODE_ALIGN) begin
      step_aln = xing.pred;
    end
    xvalid = xing.seen && (step_aln == xing.pred);
    comm   = xvalid && (s1_mode_q == MODE_RUN);

    prev_d  = prev_q;
    step_d  = step_q;
    drive_d = drive_q;
    if (s1_fire) begin
      prev_d = s1_bits_q;
      step_d = comm ? xing.code : step_aln;
      if (comm) begin
        drive_d = table_drive;
      end
    end

    res_d = res_q;
    if (s1_fire) begin
      res_d.drive = comm ? table_drive : drive_q;
      res_d.seen  = xing.seen;
      res_d.valid = xvalid;
      res_d.comm  = comm;
      res_d.step  = comm ? xing.code : step_aln;
    end

    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end

    res_valid_d = res_valid_q;
    if (s1_fire) begin
      res_valid_d = 1'b1;
    end else if (out_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      prev_q      <= '0;
      step_q      <= '0;
      drive_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
      prev_q      <= prev_d;
      step_q      <= step_d;
      drive_q     <= drive_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_bits_q <= {in_i.cross_c, in_i.cross_b, in_i.cross_a};
      s1_mode_q <= in_i.motor_mode;
      s1_duty_q <= DUTY_WIDTH'(in_i.pwm_duty);
    end
    res_q <= res_d;
  end

  assign out_o.valid          = res_valid_q;
  assign out_o.duty_a         = PwmW'(res_q.drive.duty_a);
  assign out_o.duty_b         = PwmW'(res_q.drive.duty_b);
  assign out_o.duty_c         = PwmW'(res_q.drive.duty_c);
  assign out_o.low_a_on       = res_q.drive.low_on[0];
  assign out_o.low_b_on       = res_q.drive.low_on[1];
  assign out_o.low_c_on       = res_q.drive.low_on[2];
  assign out_o.crossing_seen  = res_q.seen;
  assign out_o.crossing_valid = res_q.valid;
  assign out_o.commutated     = res_q.comm;
  assign out_o.step_now       = res_q.step;

endmodule

[hdl/bssc_checker.sv]
module bssc_checker import bssc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             low_a_on_i,
  input logic             low_b_on_i,
  input logic             low_c_on_i,
  input logic             seen_i,
  input logic             valid_i,
  input logic             comm_i,
  input logic [StepW-1:0] step_i
);

  // a valid crossing needs an edge, a commutation needs a valid crossing
  a_flag_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (!valid_i || seen_i) && (!comm_i || valid_i))
    else $error("crossing flags out of order");

  a_step_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> step_i <= STEP_LAST)
    else $error("step out of range");

  // never more than one low-side switch, exactly one right after commutation
  a_low_side : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot0({low_c_on_i, low_b_on_i, low_a_on_i}) &&
                    (!comm_i || $onehot({low_c_on_i, low_b_on_i, low_a_on_i})))
    else $error("low-side switches shoot through");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(step_i) && $stable(comm_i))
    else $error("stalled beat changed");

endmodule

bind bemf_six_step_commutator_unit bssc_checker u_bssc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .low_a_on_i  (out_o.low_a_on),
  .low_b_on_i  (out_o.low_b_on),
  .low_c_on_i  (out_o.low_c_on),
  .seen_i      (out_o.crossing_seen),
  .valid_i     (out_o.crossing_valid),
  .comm_i      (out_o.commutated),
  .step_i      (out_o.step_now)
);
